// ===== hw/rtl/key_debounce_hold_events_defines.svh =====
// Assertion macros for the key debounce and hold event block
`ifndef KEY_DEBOUNCE_HOLD_EVENTS_DEFINES_SVH
`define KEY_DEBOUNCE_HOLD_EVENTS_DEFINES_SVH

// same-cycle implication, checked after reset
`define KDHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked after reset
`define KDHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kdhe_pkg.sv =====
// Shared types, codes and constants of the key debounce and hold event block
`timescale 1ns / 1ps
package kdhe_pkg;

  localparam int unsigned RAW_BITS   = 5;
  localparam int unsigned OK_INDEX   = 2;
  localparam int unsigned BACK_INDEX = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,
    OP_GET    = 2'd1,
    OP_RESYNC = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 1'd0,
    CFG_HOLD     = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_UP        = 3'd1,
    EV_DOWN      = 3'd2,
    EV_OK        = 3'd3,
    EV_BACK      = 3'd4,
    EV_TRIG      = 3'd5,
    EV_OK_HOLD   = 3'd6,
    EV_BACK_HOLD = 3'd7
  } event_e;

  // control word fanned out to every lane
  typedef struct packed {
    logic scan;
    logic resync;
  } lane_ctl_t;

  // control word for the mailbox
  typedef struct packed {
    logic scan;
    logic get;
    logic resync;
  } merge_ctl_t;

  function automatic event_e release_code(int unsigned idx);
    event_e code;
    case (idx)
      0:       code = EV_UP;
      1:       code = EV_DOWN;
      2:       code = EV_OK;
      3:       code = EV_BACK;
      4:       code = EV_TRIG;
      default: code = EV_NONE;
    endcase
    return code;
  endfunction

  function automatic event_e hold_code(int unsigned idx);
    event_e code;
    if (idx == OK_INDEX) begin
      code = EV_OK_HOLD;
    end else if (idx == BACK_INDEX) begin
      code = EV_BACK_HOLD;
    end else begin
      code = EV_NONE;
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/kdhe_if.sv =====
// Valid/ready channel interfaces for key words and event words
`timescale 1ns / 1ps
interface kdhe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  raw_levels;
  logic [31:0] now_ms;

  modport source (output valid, output opcode, output raw_levels, output now_ms, input ready);
  modport sink   (input valid, input opcode, input raw_levels, input now_ms, output ready);
endinterface

interface kdhe_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

// ===== hw/rtl/key_debounce_hold_events.sv =====
// Top level: key debounce and hold event detector with event mailbox
//
//   channel  dir  payload                          word carries
//   in_chan  in   opcode, raw_levels, now_ms       scan / get / resync command
//   out_chan out  event_code                       mailbox contents on get
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i  debounce_ms, hold_ms
//
// One input word per cycle while input ready is high; all key lanes update in the cycle the word is taken.
// A get word shows its event in the output register in the cycle after it is taken.
// Input ready drops only while an event word waits in the output register.
// Reset: all keys released, no hold flags, stamps zero, mailbox empty.
`timescale 1ns / 1ps
`include "key_debounce_hold_events_defines.svh"
module key_debounce_hold_events #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  kdhe_in_if.sink                            in_chan,
  kdhe_out_if.source                         out_chan,
  input  logic                               cfg_we_i,
  input  logic [kdhe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kdhe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [15:0] debounce_q;
  logic [15:0] hold_ms_q;
  logic        out_valid_q;
  logic [2:0]  out_code_q;
  logic        in_take;

  kdhe_pkg::lane_ctl_t                lane_ctl;
  kdhe_pkg::merge_ctl_t               merge_ctl;
  kdhe_pkg::event_e [NUM_KEYS-1:0]    lane_ev;
  kdhe_pkg::event_e                   mailbox;

  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign in_take       = in_chan.valid && in_chan.ready;

  assign lane_ctl.scan    = in_take && (in_chan.opcode == kdhe_pkg::OP_SCAN);
  assign lane_ctl.resync  = in_take && (in_chan.opcode == kdhe_pkg::OP_RESYNC);
  assign merge_ctl.scan   = lane_ctl.scan;
  assign merge_ctl.resync = lane_ctl.resync;
  assign merge_ctl.get    = in_take && (in_chan.opcode == kdhe_pkg::OP_GET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= 16'd20;
      hold_ms_q  <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdhe_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        kdhe_pkg::CFG_HOLD:     hold_ms_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic released;
    if (k < kdhe_pkg::RAW_BITS) begin : g_raw
      assign released = in_chan.raw_levels[k];
    end else begin : g_noraw
      assign released = 1'b1;
    end

    kdhe_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (lane_ctl),
      .released_i   (released),
      .now_ms_i     (in_chan.now_ms),
      .debounce_ms_i(debounce_q),
      .hold_ms_i    (hold_ms_q),
      .rel_code_i   (kdhe_pkg::release_code(k)),
      .hold_code_i  (kdhe_pkg::hold_code(k)),
      .event_o      (lane_ev[k])
    );
  end

  kdhe_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (merge_ctl),
    .lane_ev_i(lane_ev),
    .mailbox_o(mailbox)
  );

  // output register; refills in the same cycle it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (merge_ctl.get) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_ctl.get) begin
      out_code_q <= mailbox;
    end
  end

  assign out_chan.valid      = out_valid_q;
  assign out_chan.event_code = out_code_q;

  `KDHE_ASSERT_NEXT(a_get_returns_mailbox, merge_ctl.get, out_valid_q && (out_code_q == $past(mailbox)), "get word did not return mailbox")
  `KDHE_ASSERT_NEXT(a_get_clears_mailbox, merge_ctl.get, mailbox == kdhe_pkg::EV_NONE, "mailbox not cleared by get")
  `KDHE_ASSERT_NEXT(a_first_event_kept, merge_ctl.scan && (mailbox != kdhe_pkg::EV_NONE), mailbox == $past(mailbox), "scan overwrote pending event")
  `KDHE_ASSERT_NOW(a_no_take_while_blocked, out_valid_q && !out_chan.ready, !in_take, "input taken while output word stalled")

endmodule

// ===== hw/rtl/kdhe_lane.sv =====
// One key lane: debounce, press/hold tracking and event candidate
`timescale 1ns / 1ps
module kdhe_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kdhe_pkg::lane_ctl_t ctl_i,
  input  logic                released_i,
  input  logic [31:0]         now_ms_i,
  input  logic [15:0]         debounce_ms_i,
  input  logic [15:0]         hold_ms_i,
  input  kdhe_pkg::event_e    rel_code_i,
  input  kdhe_pkg::event_e    hold_code_i,
  output kdhe_pkg::event_e    event_o
);

  logic        acc_q, acc_d;
  logic        hold_q, hold_d;
  logic [31:0] press_q, press_d;
  logic [31:0] chg_q, chg_d;

  logic [31:0] chg_age;
  logic [31:0] press_age;
  logic        differs;
  logic        take;
  logic        take_press;
  logic        hold_hit;
  logic        hold_fire;

  assign chg_age    = now_ms_i - chg_q;
  assign press_age  = now_ms_i - press_q;
  assign differs    = released_i != acc_q;
  assign take       = differs && (chg_age >= {16'd0, debounce_ms_i});
  assign take_press = take && !released_i;

  // a fresh press has age zero
  assign hold_hit  = take_press ? (hold_ms_i == 16'd0) : (press_age >= {16'd0, hold_ms_i});
  assign hold_fire = (!differs || take) && !released_i && (take_press || !hold_q) && hold_hit;

  always_comb begin
    acc_d   = acc_q;
    hold_d  = hold_q;
    press_d = press_q;
    chg_d   = chg_q;
    event_o = kdhe_pkg::EV_NONE;
    if (ctl_i.resync) begin
      acc_d   = released_i;
      hold_d  = 1'b0;
      press_d = now_ms_i;
      chg_d   = now_ms_i;
    end else if (ctl_i.scan) begin
      if (take) begin
        chg_d = now_ms_i;
        acc_d = released_i;
        if (released_i) begin
          if (!hold_q) begin
            event_o = rel_code_i;
          end
        end else begin
          press_d = now_ms_i;
          hold_d  = 1'b0;
        end
      end
      if (hold_fire) begin
        hold_d  = 1'b1;
        event_o = hold_code_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 1'b1;
      hold_q  <= 1'b0;
      press_q <= '0;
      chg_q   <= '0;
    end else begin
      acc_q   <= acc_d;
      hold_q  <= hold_d;
      press_q <= press_d;
      chg_q   <= chg_d;
    end
  end

endmodule

// ===== hw/rtl/kdhe_merge.sv =====
// Event mailbox: keeps the first lane event in key order until a get reads it or a resync clears it
`timescale 1ns / 1ps
module kdhe_merge #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kdhe_pkg::merge_ctl_t          ctl_i,
  input  kdhe_pkg::event_e [NUM_KEYS-1:0] lane_ev_i,
  output kdhe_pkg::event_e              mailbox_o
);

  kdhe_pkg::event_e mbox_q, mbox_d;
  kdhe_pkg::event_e first_ev;

  // lowest key index wins
  always_comb begin
    first_ev = kdhe_pkg::EV_NONE;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (lane_ev_i[i] != kdhe_pkg::EV_NONE) begin
        first_ev = lane_ev_i[i];
      end
    end
  end

  always_comb begin
    mbox_d = mbox_q;
    if (ctl_i.get || ctl_i.resync) begin
      mbox_d = kdhe_pkg::EV_NONE;
    end else if (ctl_i.scan && mbox_q == kdhe_pkg::EV_NONE) begin
      mbox_d = first_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbox_q <= kdhe_pkg::EV_NONE;
    end else begin
      mbox_q <= mbox_d;
    end
  end

  assign mailbox_o = mbox_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the key debounce and hold event block
`timescale 1ns / 1ps

class event_scoreboard;
  logic [15:0]         debounce_ms;
  logic [15:0]         hold_ms;
  logic [4:0]          key_up;
  logic [4:0]          hold_flag;
  logic [31:0]         press_at [kdhe_pkg::RAW_BITS];
  logic [31:0]         changed_at [kdhe_pkg::RAW_BITS];
  kdhe_pkg::event_e    held_event;
  kdhe_pkg::event_e    pending_events [$];
  int unsigned         failures;

  function new();
    debounce_ms = 16'd20;
    hold_ms     = 16'd1000;
    key_up      = '1;
    hold_flag   = '0;
    held_event  = kdhe_pkg::EV_NONE;
    failures    = 0;
    foreach (press_at[k]) begin
      press_at[k]   = '0;
      changed_at[k] = '0;
    end
  endfunction

  function void set_register(kdhe_pkg::cfg_idx_e idx, logic [15:0] value);
    if (idx == kdhe_pkg::CFG_DEBOUNCE) begin
      debounce_ms = value;
    end else begin
      hold_ms = value;
    end
  endfunction

  // first event sticks until a get word reads it
  function void post(kdhe_pkg::event_e code);
    if (code != kdhe_pkg::EV_NONE && held_event == kdhe_pkg::EV_NONE) begin
      held_event = code;
    end
  endfunction

  function void scan_keys(logic [4:0] raw, logic [31:0] stamp);
    logic        rel;
    logic        skip;
    logic [31:0] since;
    for (int k = 0; k < kdhe_pkg::RAW_BITS; k++) begin
      rel  = raw[k];
      skip = 1'b0;
      if (rel != key_up[k]) begin
        since = stamp - changed_at[k];
        if (since < {16'd0, debounce_ms}) begin
          skip = 1'b1;  // bounce: level change and hold check both dropped
        end else begin
          changed_at[k] = stamp;
          if (rel) begin
            key_up[k] = 1'b1;
            // release codes follow key order
            if (!hold_flag[k]) post(kdhe_pkg::event_e'(k + 1));
          end else begin
            key_up[k]    = 1'b0;
            press_at[k]  = stamp;
            hold_flag[k] = 1'b0;
          end
        end
      end
      if (!skip && !rel && !hold_flag[k]) begin
        since = stamp - press_at[k];
        if (since >= {16'd0, hold_ms}) begin
          hold_flag[k] = 1'b1;
          if (k == kdhe_pkg::OK_INDEX) begin
            post(kdhe_pkg::EV_OK_HOLD);
          end else if (k == kdhe_pkg::BACK_INDEX) begin
            post(kdhe_pkg::EV_BACK_HOLD);
          end
        end
      end
    end
  endfunction

  function void note_word(kdhe_pkg::opcode_e op, logic [4:0] raw, logic [31:0] stamp);
    case (op)
      kdhe_pkg::OP_SCAN: begin
        scan_keys(raw, stamp);
      end
      kdhe_pkg::OP_GET: begin
        pending_events.push_back(held_event);
        held_event = kdhe_pkg::EV_NONE;
      end
      kdhe_pkg::OP_RESYNC: begin
        key_up     = raw;
        hold_flag  = '0;
        held_event = kdhe_pkg::EV_NONE;
        foreach (press_at[k]) begin
          press_at[k]   = stamp;
          changed_at[k] = stamp;
        end
      end
      default: ;
    endcase
  endfunction

  function void report(string what, logic [2:0] want, logic [2:0] got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  function void check_event(logic [2:0] got);
    kdhe_pkg::event_e want;
    if (pending_events.size() == 0) begin
      report("event word with nothing pending", kdhe_pkg::EV_NONE, got);
    end else begin
      want = pending_events.pop_front();
      if (got !== want) report("event_code mismatch", want, got);
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASE_WORDS = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  kdhe_pkg::cfg_idx_e cfg_idx;
  logic [15:0]        cfg_data;

  kdhe_in_if  in_chan ();
  kdhe_out_if out_chan ();

  key_debounce_hold_events dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  event_scoreboard board;
  logic [31:0]     clock_ms;
  logic [4:0]      pad_levels;
  bit              no_idle;
  bit              long_stall_req;
  int unsigned     stall_left;
  int unsigned     idle_cycles;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitors sample between edges, so the edge that takes a word sees the same values
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_chan.valid && in_chan.ready) begin
        board.note_word(kdhe_pkg::opcode_e'(in_chan.opcode), in_chan.raw_levels,
                        in_chan.now_ms);
      end
      if (out_chan.valid && out_chan.ready) begin
        board.check_event(out_chan.event_code);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // event receiver
  initial begin
    out_chan.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = 300;
      end
      if (stall_left != 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) stall_left = gap_len();
      end
    end
  end

  task automatic send_word(kdhe_pkg::opcode_e op, logic [4:0] raw, logic [31:0] stamp);
    int unsigned gap;
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= op;
    in_chan.raw_levels <= raw;
    in_chan.now_ms     <= stamp;
    do @(negedge clk_i); while (!in_chan.ready);
    @(posedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = gap_len();
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_words();
    in_chan.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_events.size() != 0);
  endtask

  task automatic configure(logic [15:0] deb, logic [15:0] hold);
    cfg_we   <= 1'b1;
    cfg_idx  <= kdhe_pkg::CFG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk_i);
    cfg_idx  <= kdhe_pkg::CFG_HOLD;
    cfg_data <= hold;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    board.set_register(kdhe_pkg::CFG_DEBOUNCE, deb);
    board.set_register(kdhe_pkg::CFG_HOLD, hold);
  endtask

  task automatic advance_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      clock_ms += $urandom_range(0, 15);
    end else if (r < 90) begin
      clock_ms += $urandom_range(16, 200);
    end else if (r < 97) begin
      clock_ms += $urandom_range(201, 3000);
    end else if (r < 99) begin
      clock_ms += $urandom_range(60000, 140000);
    end else begin
      clock_ms = $urandom();
    end
  endtask

  task automatic directed_words();
    send_word(kdhe_pkg::OP_GET,    5'h1F, 32'd0);
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'd5);
    send_word(kdhe_pkg::OP_SCAN,   5'h00, 32'd30);
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'd40);    // bounce, dropped
    send_word(kdhe_pkg::OP_SCAN,   5'h00, 32'd1030);  // holds on all keys, only OK reported
    send_word(kdhe_pkg::OP_GET,    5'h00, 32'd1030);
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'd1040);  // releases after hold stay silent
    send_word(kdhe_pkg::OP_GET,    5'h1F, 32'd1040);
    send_word(kdhe_pkg::OP_SCAN,   5'h1B, 32'd1100);
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'd1150);
    send_word(kdhe_pkg::OP_SCAN,   5'h1C, 32'd1200);
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'd1250);  // second release lost to full mailbox
    send_word(kdhe_pkg::OP_GET,    5'h1F, 32'd1250);
    send_word(kdhe_pkg::OP_GET,    5'h1F, 32'd1250);
    send_word(kdhe_pkg::OP_NOP,    5'h00, 32'd2000);
    send_word(kdhe_pkg::OP_SCAN,   5'h0F, 32'd2000);
    send_word(kdhe_pkg::OP_SCAN,   5'h0F, 32'd3000);  // trig hold flagged, no code
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'd3010);
    send_word(kdhe_pkg::OP_GET,    5'h1F, 32'd3010);
    send_word(kdhe_pkg::OP_RESYNC, 5'h15, 32'hFFFF_FFF0);
    send_word(kdhe_pkg::OP_SCAN,   5'h15, 32'h0000_0010);
    send_word(kdhe_pkg::OP_SCAN,   5'h1F, 32'h0000_0020);  // stamps across the wrap
    send_word(kdhe_pkg::OP_GET,    5'h1F, 32'h0000_0020);
    send_word(kdhe_pkg::OP_SCAN,   5'h17, 32'h0000_0050);
    send_word(kdhe_pkg::OP_SCAN,   5'h17, 32'h0000_0438);
    send_word(kdhe_pkg::OP_GET,    5'h17, 32'hFFFF_FFFF);
  endtask

  task automatic random_words(int unsigned count);
    int unsigned done;
    int unsigned r;
    logic [4:0]  raw;
    done = 0;
    while (done < count) begin
      if (done % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      advance_clock();
      if (r < 62) begin
        pad_levels ^= 5'($urandom() & $urandom());
        send_word(kdhe_pkg::OP_SCAN, pad_levels, clock_ms);
      end else if (r < 88) begin
        send_word(kdhe_pkg::OP_GET, 5'($urandom()), clock_ms);
      end else if (r < 94) begin
        pad_levels = 5'($urandom());
        send_word(kdhe_pkg::OP_RESYNC, pad_levels, clock_ms);
      end else if (r < 97) begin
        raw = 5'($urandom());
        send_word(kdhe_pkg::OP_SCAN, raw, clock_ms);  // noise word off the key pattern
      end else begin
        send_word(kdhe_pkg::OP_NOP, 5'($urandom()), $urandom());
        continue;
      end
      done++;
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while words keep coming, so the output word backs up
  task automatic fill_up();
    no_idle        = 1'b1;
    long_stall_req = 1'b1;
    for (int n = 0; n < 16; n++) begin
      advance_clock();
      send_word((n % 3 == 0) ? kdhe_pkg::OP_SCAN : kdhe_pkg::OP_GET, pad_levels, clock_ms);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [15:0] deb_v;
    logic [15:0] hold_v;
    board          = new();
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= kdhe_pkg::CFG_DEBOUNCE;
    cfg_data       <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.opcode <= kdhe_pkg::OP_SCAN;
    in_chan.raw_levels <= 5'h1F;
    in_chan.now_ms <= '0;
    no_idle        = 1'b0;
    long_stall_req = 1'b0;
    idle_cycles    = 0;
    pad_levels     = 5'h1F;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_words();

    for (int p = 0; p < 7; p++) begin
      drain_words();
      repeat (3) @(posedge clk_i);
      case (p)
        0: begin deb_v = 16'd0;     hold_v = 16'd0;     end
        1: begin deb_v = 16'hFFFF;  hold_v = 16'hFFFF;  end
        2: begin deb_v = 16'd10;    hold_v = 16'd150;   end
        3: begin deb_v = 16'd3;     hold_v = 16'd40;    end
        4: begin deb_v = 16'hFFFF;  hold_v = 16'd0;     end
        5: begin deb_v = 16'd0;     hold_v = 16'hFFFF;  end
        default: begin
          deb_v  = 16'($urandom_range(0, 40));
          hold_v = 16'($urandom_range(20, 400));
        end
      endcase
      configure(deb_v, hold_v);
      clock_ms = (p % 2 == 1) ? 32'hFFFF_0000 + $urandom_range(0, 4095) : $urandom();
      pad_levels = 5'($urandom());
      send_word(kdhe_pkg::OP_RESYNC, pad_levels, clock_ms);
      if (p == 3) begin
        random_words(PHASE_WORDS / 2);
        fill_up();
        drain_words();
        random_words(PHASE_WORDS / 2);
      end else begin
        random_words(PHASE_WORDS);
      end
    end

    drain_words();
    repeat (5) @(posedge clk_i);
    if (board.pending_events.size() != 0) begin
      board.report("events never delivered", 3'(board.pending_events.size()), 3'd0);
    end
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/kdhe_pkg.sv
hw/rtl/kdhe_if.sv
hw/rtl/kdhe_lane.sv
hw/rtl/kdhe_merge.sv
hw/rtl/key_debounce_hold_events.sv
sim/tb_top.sv
